>>> hdl/assert_macros.svh
// Assertion macros shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_IFF(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold at the next clock edge (outside reset).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IFF(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/mspsh_pkg.sv
// Types and constants of the shuffled minimal standard generator.
package mspsh_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int WARMUP_STEPS  = 8;
    localparam int INIT_STEPS    = TABLE_ENTRIES + WARMUP_STEPS;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int STEP_W        = $clog2(INIT_STEPS);

    localparam logic [14:0] LEHMER_MUL = 15'd16807;
    localparam logic [31:0] LEHMER_MOD = 32'd2147483647;
    localparam logic [30:0] SAMPLE_MAX = 31'd2147483389;
    localparam logic [30:0] POWER_ON_SEED_RST = 31'd78;

    typedef struct packed {
        logic               command;
        logic signed [31:0] seed_value;
    } t_in_item;

    typedef struct packed {
        logic [30:0] sample;
        logic        saturated;
        logic [30:0] seed_out;
    } t_out_item;

    // Operand of the shared Lehmer step.
    typedef enum logic [1:0] {
        SRC_SEED,
        SRC_STATE,
        SRC_WORK
    } t_src;

    typedef struct packed {
        logic              init_load;
        logic              init_step;
        logic [STEP_W-1:0] step;
        logic              draw;
        t_src              src;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_init;
    } t_dp_stat;

endpackage

>>> hdl/mspsh_ctrl.sv
// Sequencer for draws, table initialization and the result register handshake.
module mspsh_ctrl
    import mspsh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_command,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_DRAW,
        ST_FIN
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd           = '0;
        o_cmd.src       = SRC_WORK;
        o_cmd.step      = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.need_init) begin
                        o_cmd.init_load = 1'b1;
                        n_step          = STEP_W'(INIT_STEPS - 1);
                        n_state         = ST_INIT;
                    end else begin
                        // The draw runs in the accept cycle itself.
                        o_cmd.draw = 1'b1;
                        o_cmd.src  = i_command ? SRC_SEED : SRC_STATE;
                        n_state    = ST_FIN;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_DRAW;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_DRAW: begin
                o_cmd.draw = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/mspsh_dp.sv
// Lehmer step unit, shuffle table, generator state and result register.
module mspsh_dp
    import mspsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  t_in_item    i_in_data,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    output t_out_item   o_out_data
);

    logic [30:0] r_lehmer;
    logic [30:0] r_last;
    logic [30:0] r_pos_seed;
    logic [31:0] r_work;
    logic [30:0] r_rd;
    t_out_item   r_out;
    logic [30:0] mem [TABLE_ENTRIES];

    logic [31:0] op;
    logic [46:0] prod;
    logic [31:0] fold;
    logic [30:0] nxt;
    logic [31:0] mag;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] waddr;
    logic        we;

    // Start value of an initialization: the accepted beat's seed, the power-on seed or 1.
    always_comb begin
        if (i_in_data.command) begin
            mag = i_in_data.seed_value[31] ? (~i_in_data.seed_value + 32'd1) : 32'd1;
        end else if (r_last == '0) begin
            mag = (r_pos_seed == '0) ? 32'd1 : {1'b0, r_pos_seed};
        end else begin
            mag = 32'd1;
        end
    end

    assign o_stat.need_init = (r_last == '0) ||
                              (i_in_data.command ? (i_in_data.seed_value <= 0)
                                                 : (r_lehmer == '0));

    always_comb begin
        case (i_cmd.src)
            SRC_SEED:  op = i_in_data.seed_value;
            SRC_STATE: op = {1'b0, r_lehmer};
            SRC_WORK:  op = r_work;
            default:   op = r_work;
        endcase
    end

    // Since 2^31 is 1 modulo 2^31-1, the high part folds onto the low part;
    // the sum stays below twice the modulus, so one subtract finishes it.
    assign prod = {15'd0, op} * {32'd0, LEHMER_MUL};
    assign fold = {1'b0, prod[30:0]} + {16'd0, prod[46:31]};
    assign nxt  = (fold >= LEHMER_MOD) ? 31'(fold - LEHMER_MOD) : fold[30:0];

    assign slot  = r_last[30 -: IDX_W];
    assign waddr = i_cmd.draw ? slot : i_cmd.step[IDX_W-1:0];
    assign we    = i_cmd.draw || (i_cmd.init_step && (32'(i_cmd.step) < TABLE_ENTRIES));

    // Read-first table: a draw returns the old slot content and stores the new state.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= nxt;
        end
        if (i_cmd.draw) begin
            r_rd <= mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lehmer   <= '0;
            r_last     <= '0;
            r_pos_seed <= POWER_ON_SEED_RST;
        end else begin
            if (i_cfg_we) begin
                r_pos_seed <= i_cfg_wdata;
            end
            if (i_cmd.draw) begin
                r_lehmer <= nxt;
            end
            if (i_cmd.init_step && (i_cmd.step == '0)) begin
                r_last <= nxt;
            end else if (i_cmd.out_load) begin
                r_last <= r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_load) begin
            r_work <= mag;
        end else if (i_cmd.init_step) begin
            r_work <= {1'b0, nxt};
        end
        if (i_cmd.out_load) begin
            r_out.saturated <= (r_rd > SAMPLE_MAX);
            r_out.sample    <= (r_rd > SAMPLE_MAX) ? SAMPLE_MAX : r_rd;
            r_out.seed_out  <= r_lehmer;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> hdl/minimal_standard_prng_shuffled_top.sv
// Shuffled minimal standard generator: one result beat for every input beat. A normal
// draw does the modular step and the read-first table swap in the accept cycle, then
// takes the old slot content as the new last output and loads the result register once
// that is free. A beat that needs initialization (a seed of zero or below, a zero state,
// or a table not yet filled, as after reset) first runs 40 steps of the single Lehmer
// step unit to fill the table, then the draw and the result load follow. The first
// beat after reset always initializes; there is no clearing pass. The next beat is
// accepted as soon as the result is in the output register, even while it is stalled.
`include "assert_macros.svh"

module minimal_standard_prng_shuffled_top
    import mspsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mspsh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_data.command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    mspsh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "accepted beat did not make the block busy")
    `ASSERT_IFF(a_load_when_free, i_clk, i_rst_n, !dp_cmd.out_load || !o_out_valid || !i_out_stall, "result loaded over a stalled beat")
    `ASSERT_IFF(a_draw_not_init, i_clk, i_rst_n, !(dp_cmd.draw && (dp_cmd.init_step || dp_cmd.init_load)), "draw overlaps initialization")
    `ASSERT_IFF(a_sample_clamped, i_clk, i_rst_n, !o_out_valid || ((o_out_data.sample <= SAMPLE_MAX) && (!o_out_data.saturated || (o_out_data.sample == SAMPLE_MAX))), "sample outside clamp")

endmodule
